// ===== rtl/mec_pkg.sv =====
package mec_pkg;

	localparam int ITER_CAP_DEF   = 255;
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 28;

	localparam int CTR_W      = 12;
	localparam int SCALE_W    = 24;
	localparam int CNT_W      = 8;
	localparam int CNT_MAX    = (1 << CNT_W) - 1;
	localparam int HUE_W      = 15;
	localparam int SHIFT_W    = 8;
	localparam int IDX_W      = 8;
	localparam int COL_W      = 8;
	localparam int V_FRAC     = 16;
	localparam int V_W        = V_FRAC + 1;
	localparam int DVD_W      = CNT_W + V_FRAC;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int PAL_DEPTH  = 1 << IDX_W;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_OFFSET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_ROTATE = 3'd5;

	localparam logic [CTR_W-1:0]   ORIGIN_COL_RST   = 12'd600;
	localparam logic [CTR_W-1:0]   ORIGIN_ROW_RST   = 12'd400;
	localparam logic [SCALE_W-1:0] SCALE_RST        = 24'd83886;
	localparam logic [CNT_W-1:0]   MAX_ITER_RST     = 8'd150;
	localparam logic [HUE_W-1:0]   HUE_OFFSET_RST   = 15'd0;
	localparam logic [SHIFT_W-1:0] INDEX_ROTATE_RST = 8'd0;

	typedef struct packed {
		logic [CTR_W-1:0]         origin_col;
		logic [CTR_W-1:0]         origin_row;
		logic [SCALE_W-1:0]       scale;
		logic [CNT_W-1:0]         limit;
		logic signed [HUE_W-1:0]  hue_offset;
		logic [SHIFT_W-1:0]       index_rotate;
	} mec_cfg_t;

	typedef struct packed {
		logic load_in;
		logic map;
		logic init;
		logic mul;
		logic upd;
		logic div_start;
		logic hue;
		logic idx;
		logic rom;
		logic load_out;
	} mec_cmd_t;

	typedef struct packed {
		logic below_limit;
		logic out_of_bounds;
		logic escaped;
		logic div_done;
	} mec_sts_t;

	typedef logic [3*COL_W-1:0] pal_rom_t [PAL_DEPTH];

	localparam logic [63:0] Q60_ONE     = 64'h1000000000000000;
	localparam logic [63:0] Q60_PI      = 64'h3243F6A8885A308D;
	localparam logic [63:0] Q60_HALF_PI = 64'h1921FB54442D1846;
	localparam logic [63:0] Q60_TWO_PI  = 64'h6487ED5110B4611A;

	function automatic logic [63:0] pal_mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Taylor series of the sine over the first quadrant, Q60 in and out.
	function automatic logic [63:0] pal_sine(input logic [63:0] a);
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] sum;
		a2   = pal_mul_q60(a, a);
		term = a;
		sum  = a;
		term = pal_mul_q60(term, a2) / 64'd6;   sum = sum - term;
		term = pal_mul_q60(term, a2) / 64'd20;  sum = sum + term;
		term = pal_mul_q60(term, a2) / 64'd42;  sum = sum - term;
		term = pal_mul_q60(term, a2) / 64'd72;  sum = sum + term;
		term = pal_mul_q60(term, a2) / 64'd110; sum = sum - term;
		term = pal_mul_q60(term, a2) / 64'd156; sum = sum + term;
		term = pal_mul_q60(term, a2) / 64'd210; sum = sum - term;
		term = pal_mul_q60(term, a2) / 64'd272; sum = sum + term;
		term = pal_mul_q60(term, a2) / 64'd342; sum = sum - term;
		term = pal_mul_q60(term, a2) / 64'd420; sum = sum + term;
		term = pal_mul_q60(term, a2) / 64'd506; sum = sum - term;
		return sum;
	endfunction

	function automatic logic [COL_W-1:0] pal_wave(input logic [63:0] ang);
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] u;
		logic [63:0] b;
		logic        neg;
		x   = ang;
		neg = 1'b0;
		if (x >= Q60_TWO_PI) x = x - Q60_TWO_PI;
		if (x >= Q60_TWO_PI) x = x - Q60_TWO_PI;
		if (x >= Q60_PI) begin
			x   = x - Q60_PI;
			neg = 1'b1;
		end
		if (x > Q60_HALF_PI) x = Q60_PI - x;
		s = pal_sine(x);
		if (s > Q60_ONE) s = Q60_ONE;
		u = neg ? (Q60_ONE - s) : (Q60_ONE + s);
		b = (64'd255 * (u >> 21) + 64'd4096) >> 41;
		return (b > 64'd255) ? 8'hFF : b[COL_W-1:0];
	endfunction

	function automatic pal_rom_t pal_build();
		pal_rom_t    rom;
		logic [63:0] ang;
		for (int i = 0; i < PAL_DEPTH; i++) begin
			ang = (Q60_PI >> 7) * 64'(i) + (((Q60_PI & 64'd127) * 64'(i)) >> 7);
			rom[i] = {pal_wave(ang), pal_wave(ang + (64'd2 << 60)),
				pal_wave(ang + (64'd4 << 60))};
		end
		return rom;
	endfunction

	localparam pal_rom_t PALETTE_ROM = pal_build();

endpackage

// ===== rtl/mec_div.sv =====
module mec_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mec_pkg::CNT_W-1:0]     dividend,
	input  logic [mec_pkg::CNT_W-1:0]     divisor,
	output logic [mec_pkg::V_W-1:0]       quotient,
	output logic                          done
);
	import mec_pkg::*;

	localparam int STEP_W = $clog2(DVD_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {dividend, V_FRAC'(0)};
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign quotient = quo_q[V_W-1:0];
	assign done     = done_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dsr_q) || (dsr_q == '0))
		else $error("Divider remainder not below divisor at completion.");

endmodule

// ===== rtl/mec_dp.sv =====
module mec_dp #(
	parameter int COORD_BITS = mec_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = mec_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mec_pkg::mec_cfg_t           cfg,
	input  mec_pkg::mec_cmd_t           cmd,
	output mec_pkg::mec_sts_t           sts,
	input  logic [COORD_BITS-1:0]       pixel_x,
	input  logic [COORD_BITS-1:0]       pixel_y,
	output logic [mec_pkg::CNT_W-1:0]   escape_count,
	output logic [mec_pkg::IDX_W-1:0]   palette_index,
	output logic [mec_pkg::COL_W-1:0]   red,
	output logic [mec_pkg::COL_W-1:0]   green,
	output logic [mec_pkg::COL_W-1:0]   blue
);
	import mec_pkg::*;

	localparam int D_W   = ((COORD_BITS > CTR_W) ? COORD_BITS : CTR_W) + 1;
	localparam int MP_W  = D_W + SCALE_W + 1;
	localparam int EXT_W = MP_W + FRAC_BITS;
	localparam int W     = D_W + FRAC_BITS + 3;
	localparam int OP_W  = FRAC_BITS + 2;
	localparam int SQ_W  = 2 * OP_W;
	localparam int XP_W  = 2 * OP_W + 1;
	localparam int RR_W  = SQ_W - FRAC_BITS;
	localparam int XR_W  = XP_W - FRAC_BITS;

	localparam logic signed [W-1:0]   TWO_FX     = signed'(W'(2) << FRAC_BITS);
	localparam logic signed [W-1:0]   NEG_TWO_FX = -TWO_FX;
	localparam logic signed [W-1:0]   FOUR_FX    = signed'(W'(4) << FRAC_BITS);
	localparam logic signed [V_W:0]   ONE_V      = signed'((V_W + 1)'(1) << V_FRAC);

	logic [COORD_BITS-1:0]    pix_x_q, pix_y_q;
	logic signed [D_W-1:0]    dx, dy;
	logic signed [MP_W-1:0]   mp_x_q, mp_y_q;
	logic signed [EXT_W-1:0]  cx_ext, cy_ext, cx_sh, cy_sh;
	logic signed [W-1:0]      cx_q, cy_q, re_q, im_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [OP_W-1:0]   re_op, im_op;
	logic signed [OP_W:0]     re2_op;
	logic signed [SQ_W-1:0]   rr_prod_q, ii_prod_q;
	logic signed [XP_W-1:0]   xp_prod_q;
	logic signed [RR_W-1:0]   rr, ii;
	logic signed [XR_W-1:0]   xr;
	logic signed [W-1:0]      mag_sum;
	logic [V_W-1:0]           quot;
	logic                     div_done;
	logic [V_W-1:0]           v_raw;
	logic signed [V_W:0]      v_sum, v_wrap;
	logic [V_W-1:0]           v_q;
	logic [V_W+IDX_W-1:0]     v255;
	logic [IDX_W-1:0]         idx_q;
	logic [3*COL_W-1:0]       rgb_q;

	assign dx = signed'(D_W'(pix_x_q)) - signed'(D_W'(cfg.origin_col));
	assign dy = signed'(D_W'(pix_y_q)) - signed'(D_W'(cfg.origin_row));

	assign cx_ext = EXT_W'(mp_x_q);
	assign cy_ext = EXT_W'(mp_y_q);

	if (FRAC_BITS >= SCALE_W) begin : g_shift_up
		assign cx_sh = cx_ext <<< (FRAC_BITS - SCALE_W);
		assign cy_sh = cy_ext <<< (FRAC_BITS - SCALE_W);
	end else begin : g_shift_down
		assign cx_sh = cx_ext >>> (SCALE_W - FRAC_BITS);
		assign cy_sh = cy_ext >>> (SCALE_W - FRAC_BITS);
	end

	// The operands are only used while both parts lie strictly between minus two and two.
	assign re_op  = signed'(re_q[OP_W-1:0]);
	assign im_op  = signed'(im_q[OP_W-1:0]);
	assign re2_op = signed'({re_op, 1'b0});

	assign rr      = signed'(rr_prod_q[SQ_W-1:FRAC_BITS]);
	assign ii      = signed'(ii_prod_q[SQ_W-1:FRAC_BITS]);
	assign xr      = signed'(xp_prod_q[XP_W-1:FRAC_BITS]);
	assign mag_sum = W'(rr) + W'(ii);

	assign sts.below_limit   = count_q < cfg.limit;
	assign sts.out_of_bounds = (re_q >= TWO_FX) || (re_q <= NEG_TWO_FX) ||
		(im_q >= TWO_FX) || (im_q <= NEG_TWO_FX);
	assign sts.escaped       = mag_sum >= FOUR_FX;
	assign sts.div_done      = div_done;

	mec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (count_q),
		.divisor  (cfg.limit),
		.quotient (quot),
		.done     (div_done)
	);

	assign v_raw = (cfg.limit == '0) ? '0 : quot;
	assign v_sum = signed'({1'b0, v_raw}) + (V_W + 1)'(cfg.hue_offset);

	always_comb begin
		if (v_sum < 0) begin
			v_wrap = v_sum + ONE_V;
		end else if (v_sum > ONE_V) begin
			v_wrap = v_sum - ONE_V;
		end else begin
			v_wrap = v_sum;
		end
	end

	assign v255 = {v_q, IDX_W'(0)} - (V_W + IDX_W)'(v_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pix_x_q <= pixel_x;
			pix_y_q <= pixel_y;
		end
		if (cmd.map) begin
			mp_x_q <= MP_W'(dx) * MP_W'(signed'({1'b0, cfg.scale}));
			mp_y_q <= MP_W'(dy) * MP_W'(signed'({1'b0, cfg.scale}));
		end
		if (cmd.init) begin
			cx_q    <= signed'(cx_sh[W-1:0]);
			cy_q    <= signed'(cy_sh[W-1:0]);
			re_q    <= signed'(cx_sh[W-1:0]);
			im_q    <= signed'(cy_sh[W-1:0]);
			count_q <= '0;
		end
		if (cmd.mul) begin
			rr_prod_q <= SQ_W'(re_op) * SQ_W'(re_op);
			ii_prod_q <= SQ_W'(im_op) * SQ_W'(im_op);
			xp_prod_q <= XP_W'(re2_op) * XP_W'(im_op);
		end
		if (cmd.upd) begin
			re_q    <= W'(rr) - W'(ii) + cx_q;
			im_q    <= W'(xr) + cy_q;
			count_q <= count_q + 1'b1;
		end
		if (cmd.hue) begin
			v_q <= v_wrap[V_W-1:0];
		end
		if (cmd.idx) begin
			idx_q <= v255[V_FRAC+IDX_W-1:V_FRAC] + cfg.index_rotate;
		end
		if (cmd.rom) begin
			rgb_q <= PALETTE_ROM[idx_q];
		end
		if (cmd.load_out) begin
			escape_count  <= count_q;
			palette_index <= idx_q;
			red           <= rgb_q[3*COL_W-1:2*COL_W];
			green         <= rgb_q[2*COL_W-1:COL_W];
			blue          <= rgb_q[COL_W-1:0];
		end
	end

	a_update_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> (count_q < cfg.limit))
		else $error("Iteration step taken with the count already at the limit.");

endmodule

// ===== rtl/mec_ctrl.sv =====
module mec_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mec_pkg::mec_sts_t  sts,
	output mec_pkg::mec_cmd_t  cmd
);
	import mec_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MAP   = 4'd1;
	localparam logic [3:0] S_INIT  = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_ADD   = 4'd4;
	localparam logic [3:0] S_DIVST = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_HUE   = 4'd7;
	localparam logic [3:0] S_IDX   = 4'd8;
	localparam logic [3:0] S_ROM   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) state_d = S_MAP;
			end
			S_MAP: begin
				cmd.map = 1'b1;
				state_d = S_INIT;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (!sts.below_limit || sts.out_of_bounds) begin
					state_d = S_DIVST;
				end else begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				if (sts.escaped) begin
					state_d = S_DIVST;
				end else begin
					cmd.upd = 1'b1;
					state_d = S_MUL;
				end
			end
			S_DIVST: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_HUE;
			end
			S_HUE: begin
				cmd.hue = 1'b1;
				state_d = S_IDX;
			end
			S_IDX: begin
				cmd.idx = 1'b1;
				state_d = S_ROM;
			end
			S_ROM: begin
				cmd.rom = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("Result register loaded while holding an untaken transaction.");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_DIV))
		else $error("Divider finished while the controller was not waiting for it.");

	a_load_leaves_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> in_ready)
		else $error("Controller did not return to accept input after a result.");

endmodule

// ===== rtl/mandelbrot_escape_colorizer.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    pixel_x, pixel_y
// out       output     out_valid / out_ready  escape_count, palette_index, red, green, blue
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After a transaction is accepted, each iteration is a multiply state and an add state, and a
// point that escapes on magnitude leaves from the add state. The count-to-fraction division
// produces one bit a cycle for 24 bits.
// Reset clears the controller and loads the register defaults; the palette is a constant table.
// A finished result waits in the output register while the next transaction is accepted;
// a second result then waits in the controller until the output register is taken.
// Configuration writes are always accepted.
module mandelbrot_escape_colorizer #(
	parameter int ITER_CAP   = mec_pkg::ITER_CAP_DEF,
	parameter int COORD_BITS = mec_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = mec_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS-1:0]             pixel_x,
	input  logic [COORD_BITS-1:0]             pixel_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mec_pkg::CNT_W-1:0]         escape_count,
	output logic [mec_pkg::IDX_W-1:0]         palette_index,
	output logic [mec_pkg::COL_W-1:0]         red,
	output logic [mec_pkg::COL_W-1:0]         green,
	output logic [mec_pkg::COL_W-1:0]         blue,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mec_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mec_pkg::*;

	localparam int              CAP_CLAMP = (ITER_CAP < CNT_MAX) ? ITER_CAP : CNT_MAX;
	localparam logic [CNT_W-1:0] CAP_LIM  = CNT_W'(CAP_CLAMP);

	logic [CTR_W-1:0]        origin_col_q, origin_row_q;
	logic [SCALE_W-1:0]      scale_q;
	logic [CNT_W-1:0]        max_iter_q;
	logic signed [HUE_W-1:0] hue_offset_q;
	logic [SHIFT_W-1:0]      index_rotate_q;
	mec_cfg_t                cfg;
	mec_cmd_t                cmd;
	mec_sts_t                sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_col_q   <= ORIGIN_COL_RST;
			origin_row_q   <= ORIGIN_ROW_RST;
			scale_q        <= SCALE_RST;
			max_iter_q     <= MAX_ITER_RST;
			hue_offset_q   <= signed'(HUE_OFFSET_RST);
			index_rotate_q <= INDEX_ROTATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN_COL:   origin_col_q   <= cfg_data[CTR_W-1:0];
				REG_ORIGIN_ROW:   origin_row_q   <= cfg_data[CTR_W-1:0];
				REG_SCALE:        scale_q        <= cfg_data[SCALE_W-1:0];
				REG_MAX_ITER:     max_iter_q     <= cfg_data[CNT_W-1:0];
				REG_HUE_OFFSET:   hue_offset_q   <= signed'(cfg_data[HUE_W-1:0]);
				REG_INDEX_ROTATE: index_rotate_q <= cfg_data[SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.origin_col   = origin_col_q;
		cfg.origin_row   = origin_row_q;
		cfg.scale        = scale_q;
		cfg.limit        = (max_iter_q > CAP_LIM) ? CAP_LIM : max_iter_q;
		cfg.hue_offset   = hue_offset_q;
		cfg.index_rotate = index_rotate_q;
	end

	mec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mec_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.escape_count  (escape_count),
		.palette_index (palette_index),
		.red           (red),
		.green         (green),
		.blue          (blue)
	);

endmodule

// ===== verif/mandelbrot_escape_colorizer_tb.sv =====
module mandelbrot_escape_colorizer_tb;
	import mec_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	localparam logic [63:0] ONE_Q60     = 64'h1000000000000000;
	localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
	localparam logic [63:0] PI2_Q60     = 64'h6487ED5110B4611A;

	localparam longint FX_TWO  = longint'(2) <<< FRAC_BITS_DEF;
	localparam longint FX_FOUR = longint'(4) <<< FRAC_BITS_DEF;

	typedef struct {
		logic [CTR_W-1:0]        origin_col;
		logic [CTR_W-1:0]        origin_row;
		logic [SCALE_W-1:0]      scale;
		logic [CNT_W-1:0]        iters;
		logic signed [HUE_W-1:0] hue;
		logic [SHIFT_W-1:0]      shift;
	} view_t;

	typedef struct packed {
		logic [COORD_BITS_DEF-1:0] x;
		logic [COORD_BITS_DEF-1:0] y;
	} coord_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] index;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} pixel_colour_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [COORD_BITS_DEF-1:0] pixel_x = '0;
	logic [COORD_BITS_DEF-1:0] pixel_y = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [CNT_W-1:0]          escape_count;
	logic [IDX_W-1:0]          palette_index;
	logic [COL_W-1:0]          red;
	logic [COL_W-1:0]          green;
	logic [COL_W-1:0]          blue;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	logic [3*COL_W-1:0] sine_palette [PAL_DEPTH];
	view_t              model_view;
	coord_t             pending_pixels [$];
	pixel_colour_t      expected_colours [$];
	int                 in_idle_pct = 0;
	int                 out_stall_pct = 0;
	int                 errors = 0;

	mandelbrot_escape_colorizer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.escape_count (escape_count),
		.palette_index(palette_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[123:60];
	endfunction

	function automatic logic [COL_W-1:0] wave_level(input logic [63:0] ang);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] u;
		logic [63:0] b;
		logic        neg;
		a   = ang;
		neg = 1'b0;
		while (a >= PI2_Q60)
			a = a - PI2_Q60;
		if (a >= PI_Q60) begin
			a   = a - PI_Q60;
			neg = 1'b1;
		end
		if (a > HALF_PI_Q60)
			a = PI_Q60 - a;
		a2   = q60_mul(a, a);
		term = a;
		sum  = a;
		for (int k = 1; k <= 11; k++) begin
			term = q60_mul(term, a2) / 64'(2 * k * (2 * k + 1));
			sum  = (k % 2 != 0) ? sum - term : sum + term;
		end
		if (sum > ONE_Q60)
			sum = ONE_Q60;
		u = neg ? ONE_Q60 - sum : ONE_Q60 + sum;
		b = (64'd255 * (u >> 21) + 64'd4096) >> 41;
		return (b > 64'd255) ? 8'hFF : b[COL_W-1:0];
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		logic signed [127:0] p;
		p = a * b;
		return longint'(p >>> FRAC_BITS_DEF);
	endfunction

	function automatic longint map_axis(input logic [CTR_W-1:0] pix, input logic [CTR_W-1:0] ctr,
		input logic [SCALE_W-1:0] scl);
		longint d;
		longint m;
		d = longint'(pix) - longint'(ctr);
		m = ((d < 0) ? -d : d) * longint'(scl);
		m = m <<< (FRAC_BITS_DEF - SCALE_W);
		return (d < 0) ? -m : m;
	endfunction

	function automatic pixel_colour_t shade_pixel(input logic [COORD_BITS_DEF-1:0] x,
		input logic [COORD_BITS_DEF-1:0] y);
		longint        cx;
		longint        cy;
		longint        re;
		longint        im;
		longint        rr;
		longint        ii;
		longint        nim;
		longint        v;
		int            count;
		int            limit;
		int            idx;
		logic          done;
		pixel_colour_t c;
		cx    = map_axis(x, model_view.origin_col, model_view.scale);
		cy    = map_axis(y, model_view.origin_row, model_view.scale);
		re    = cx;
		im    = cy;
		count = 0;
		limit = int'(model_view.iters);
		done  = 1'b0;
		while (!done && count < limit) begin
			if (re >= FX_TWO || re <= -FX_TWO || im >= FX_TWO || im <= -FX_TWO) begin
				done = 1'b1;
			end else begin
				rr = fx_mul(re, re);
				ii = fx_mul(im, im);
				if (rr + ii >= FX_FOUR) begin
					done = 1'b1;
				end else begin
					nim   = fx_mul(2 * re, im) + cy;
					re    = rr - ii + cx;
					im    = nim;
					count = count + 1;
				end
			end
		end
		v = (limit != 0) ? (longint'(count) <<< 16) / limit : 0;
		v = v + longint'(model_view.hue);
		if (v < 0)
			v = v + 65536;
		if (v > 65536)
			v = v - 65536;
		idx     = int'(((v * 255) >>> 16) + longint'(model_view.shift)) & 255;
		c.count = count[CNT_W-1:0];
		c.index = idx[IDX_W-1:0];
		c.red   = sine_palette[idx][23:16];
		c.green = sine_palette[idx][15:8];
		c.blue  = sine_palette[idx][7:0];
		return c;
	endfunction

	function automatic view_t make_view(input int cx, input int cy, input int scl,
		input int it, input int hue, input int sh);
		view_t v;
		v.origin_col = CTR_W'(cx);
		v.origin_row = CTR_W'(cy);
		v.scale      = SCALE_W'(scl);
		v.iters      = CNT_W'(it);
		v.hue        = HUE_W'(hue);
		v.shift      = SHIFT_W'(sh);
		return v;
	endfunction

	function automatic view_t random_view(input logic wide);
		view_t v;
		v.origin_col = CTR_W'($urandom_range(0, 4095));
		v.origin_row = CTR_W'($urandom_range(0, 4095));
		v.scale      = wide ? SCALE_W'($urandom_range(1, 16777215))
			: SCALE_W'($urandom_range(2048, 400000));
		v.iters      = ($urandom_range(9) == 0) ? '0 : CNT_W'($urandom_range(1, 255));
		v.hue        = HUE_W'($urandom);
		v.shift      = SHIFT_W'($urandom);
		return v;
	endfunction

	// Most points land within about 2.5 units of the centre so that the escape loop runs deep.
	function automatic logic [COORD_BITS_DEF-1:0] aim_pixel(input logic [CTR_W-1:0] ctr);
		int reach;
		int p;
		if ($urandom_range(99) < 20)
			return COORD_BITS_DEF'($urandom_range(0, 4095));
		reach = 41943040 / int'(model_view.scale);
		if (reach > 4095)
			reach = 4095;
		if (reach < 1)
			reach = 1;
		p = int'(ctr) + int'($urandom_range(0, 2 * reach)) - reach;
		if (p < 0)
			p = 0;
		if (p > 4095)
			p = 4095;
		return COORD_BITS_DEF'(p);
	endfunction

	task automatic queue_pixel(input int x, input int y);
		pending_pixels.push_back({COORD_BITS_DEF'(x), COORD_BITS_DEF'(y)});
	endtask

	task automatic drain_pixels();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_colours.size() != 0);
		@(posedge clk);
	endtask

	// The valid is left high between back-to-back writes and lowered by the caller.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_ORIGIN_COL:   model_view.origin_col = data[CTR_W-1:0];
			REG_ORIGIN_ROW:   model_view.origin_row = data[CTR_W-1:0];
			REG_SCALE:        model_view.scale      = data[SCALE_W-1:0];
			REG_MAX_ITER:     model_view.iters      = data[CNT_W-1:0];
			REG_HUE_OFFSET:   model_view.hue        = data[HUE_W-1:0];
			REG_INDEX_ROTATE: model_view.shift      = data[SHIFT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_view(input view_t v);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_ORIGIN_COL, {junk[23:12], v.origin_col});
		write_reg(REG_ORIGIN_ROW, {junk[11:0], v.origin_row});
		write_reg(REG_UNUSED_LO, junk);
		write_reg(REG_SCALE, v.scale);
		write_reg(REG_MAX_ITER, {junk[15:0], v.iters});
		write_reg(REG_HUE_OFFSET, {junk[8:0], v.hue});
		write_reg(REG_INDEX_ROTATE, {junk[23:8], v.shift});
		write_reg(REG_UNUSED_HI, ~junk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : drive_pixels
		coord_t pt;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_colours.push_back(shade_pixel(pixel_x, pixel_y));
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
					pt = pending_pixels.pop_front();
					in_valid <= 1'b1;
					pixel_x  <= pt.x;
					pixel_y  <= pt.y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_results
		pixel_colour_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_colours.size() == 0) begin
					$error("output transaction with no pixel outstanding");
					errors++;
				end else begin
					want = expected_colours.pop_front();
					check_field("escape_count", want.count, escape_count);
					check_field("palette_index", want.index, palette_index);
					check_field("red", want.red, red);
					check_field("green", want.green, green);
					check_field("blue", want.blue, blue);
				end
			end
			out_ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	initial begin
		logic [63:0] ang;
		view_t       v;
		for (int i = 0; i < PAL_DEPTH; i++) begin
			ang = (PI_Q60 >> 7) * 64'(i) + (((PI_Q60 & 64'd127) * 64'(i)) >> 7);
			sine_palette[i] = {wave_level(ang), wave_level(ang + (64'd2 << 60)),
				wave_level(ang + (64'd4 << 60))};
		end
		model_view = make_view(600, 400, 83886, 150, 0, 0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults: the centre runs to the limit, the corners escape at once.
		queue_pixel(600, 400);
		queue_pixel(0, 0);
		queue_pixel(4095, 4095);
		queue_pixel(4095, 0);
		queue_pixel(0, 4095);
		queue_pixel(623, 400);
		queue_pixel(361, 400);
		queue_pixel(500, 450);
		drain_pixels();

		// A zero limit, with the most negative hue offset and the largest shift.
		apply_view(make_view(2048, 2048, 16384, 0, -16384, 255));
		queue_pixel(2048, 2048);
		queue_pixel(0, 0);
		queue_pixel(4095, 4095);
		drain_pixels();

		apply_view(make_view(4095, 0, 1, 255, 16383, 0));
		queue_pixel(0, 4095);
		queue_pixel(4095, 0);
		drain_pixels();

		apply_view(make_view(0, 0, 16777215, 255, 13107, 128));
		queue_pixel(1, 0);
		queue_pixel(2, 0);
		queue_pixel(0, 2);
		queue_pixel(4095, 4095);
		drain_pixels();

		apply_view(make_view(2048, 2048, 16384, 1, -13107, 7));
		queue_pixel(2048, 2048);
		queue_pixel(0, 0);
		drain_pixels();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       v = make_view(600, 400, 83886, 150, 0, 0);
				1:       v = make_view(0, 0, 1, 255, 16383, 255);
				2:       v = make_view(4095, 4095, 16777215, 1, -16384, 0);
				default: v = random_view(p == 7);
			endcase
			apply_view(v);
			case (p % 4)
				0: begin
					in_idle_pct   = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_idle_pct   = 64;
					out_stall_pct = 0;
				end
				2: begin
					in_idle_pct   = 0;
					out_stall_pct = 64;
				end
				default: begin
					in_idle_pct   = 38;
					out_stall_pct = 38;
				end
			endcase
			// Each phase is sent in two halves with a full drain in between.
			for (int h = 0; h < 2; h++) begin
				for (int n = 0; n < 78; n++)
					pending_pixels.push_back({aim_pixel(model_view.origin_col),
						aim_pixel(model_view.origin_row)});
				drain_pixels();
			end
		end

		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#8000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
